[hw/rtl/mpmf_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-pattern mask filter package
// Shared constants, codes and types for the mask filter and its parts.
// ----------------------------------------------------------------------------
package mpmf_pkg;

   // Machine size.
   localparam int NumStates   = 256;
   localparam int StateW      = $clog2(NumStates);
   localparam int SymW        = 8;
   localparam int EdgeAddrW   = StateW + SymW;
   localparam int MaxPattern  = 16;
   localparam int WinIdxW     = $clog2(MaxPattern);
   localparam int FillW       = $clog2(MaxPattern + 1);
   localparam int LenW        = 5;
   localparam int StepW       = $clog2(NumStates + 1);

   // Folding range for case-insensitive matching.
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;

   // Request action codes.
   typedef enum logic [1:0] {
      ACT_SCAN      = 2'd0,
      ACT_END       = 2'd1,
      ACT_EDGE_WR   = 2'd2,
      ACT_STATE_WR  = 2'd3
   } action_type;

   // Response kinds.
   typedef enum logic [1:0] {
      KIND_PLAIN = 2'd0,
      KIND_MASK  = 2'd1,
      KIND_NONE  = 2'd2
   } kind_type;

   // Window entry: bit 8 is the mask marker, bits 7..0 the byte.
   typedef logic [8:0] win_entry_type;

   // Window operations.
   typedef enum logic [1:0] {
      WIN_NOP   = 2'd0,
      WIN_SHIFT = 2'd1,
      WIN_POP   = 2'd2,
      WIN_PUSH  = 2'd3
   } win_op_type;

   typedef struct packed {
      win_op_type    op;
      win_entry_type data;
   } win_ctl_type;

   typedef struct packed {
      win_entry_type    head;
      win_entry_type    tail;
      logic [FillW-1:0] fill;
   } win_status_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_SHIFT,
      ST_SCAN_PUSH,
      ST_EDGE_RD,
      ST_EDGE_CHK,
      ST_FAIL_RD,
      ST_FAIL_CHK,
      ST_LEN_RD,
      ST_LEN_CHK,
      ST_MASK,
      ST_FLUSH
   } seq_state_type;

endpackage

[hw/rtl/mpmf_edge_mem.sv]
// ----------------------------------------------------------------------------
// Edge table memory
// Goto edges, one word per state and symbol, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module mpmf_edge_mem (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [mpmf_pkg::EdgeAddrW-1:0]       wr_addr,
   input  logic [8:0]                           wr_data,
   input  logic [mpmf_pkg::EdgeAddrW-1:0]       rd_addr,
   output logic [8:0]                           rd_data,
   output logic                                 busy
);

   localparam int Depth = 1 << mpmf_pkg::EdgeAddrW;

   logic [8:0]                     mem [Depth];
   logic [8:0]                     rd_data_ff;
   logic                           clr_busy_ff;
   logic                           clr_busy_in;
   logic [mpmf_pkg::EdgeAddrW-1:0] clr_addr_ff;
   logic [mpmf_pkg::EdgeAddrW-1:0] clr_addr_in;

   // Clearing sweep control.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == mpmf_pkg::EdgeAddrW'(Depth - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Single write port, registered read.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

[hw/rtl/mpmf_state_mem.sv]
// ----------------------------------------------------------------------------
// State information memory
// Fail link and match length per state, with valid bits for zero reset.
// ----------------------------------------------------------------------------
module mpmf_state_mem (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [mpmf_pkg::StateW-1:0]          wr_addr,
   input  logic [mpmf_pkg::StateW-1:0]          wr_fail,
   input  logic [mpmf_pkg::LenW-1:0]            wr_len,
   input  logic [mpmf_pkg::StateW-1:0]          rd_addr,
   output logic [mpmf_pkg::StateW-1:0]          rd_fail,
   output logic [mpmf_pkg::LenW-1:0]            rd_len
);

   localparam int WordW = mpmf_pkg::StateW + mpmf_pkg::LenW;

   logic [WordW-1:0]               mem [mpmf_pkg::NumStates];
   logic [mpmf_pkg::NumStates-1:0] valid_ff;
   logic [WordW-1:0]               rd_word_ff;
   logic                           rd_valid_ff;

   // Valid bits clear at reset; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_fail, wr_len};
      end
      rd_word_ff <= mem[rd_addr];
   end

   assign rd_fail = rd_valid_ff ? rd_word_ff[WordW-1:mpmf_pkg::LenW] : '0;
   assign rd_len  = rd_valid_ff ? rd_word_ff[mpmf_pkg::LenW-1:0] : '0;

endmodule

[hw/rtl/mpmf_window.sv]
// ----------------------------------------------------------------------------
// Delay window
// Holds the most recent bytes and mask markers until they are released.
// ----------------------------------------------------------------------------
module mpmf_window (
   input  logic                           clock,
   input  logic                           reset,
   input  mpmf_pkg::win_ctl_type          ctl,
   output mpmf_pkg::win_status_type       status
);

   mpmf_pkg::win_entry_type         win_ff [mpmf_pkg::MaxPattern];
   logic [mpmf_pkg::FillW-1:0]      fill_ff;
   logic [mpmf_pkg::FillW-1:0]      fill_in;
   logic [mpmf_pkg::FillW-1:0]      tail_pos;

   // Fill count.
   always_comb begin
      fill_in = fill_ff;
      case (ctl.op)
         mpmf_pkg::WIN_SHIFT: fill_in = fill_ff - 1'b1;
         mpmf_pkg::WIN_POP:   fill_in = fill_ff - 1'b1;
         mpmf_pkg::WIN_PUSH:  fill_in = fill_ff + 1'b1;
         default:             fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Entry storage: shift toward the head, or write at the fill position.
   always_ff @(posedge clock) begin
      if (ctl.op == mpmf_pkg::WIN_SHIFT) begin
         for (int i = 0; i < mpmf_pkg::MaxPattern - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
      end else if (ctl.op == mpmf_pkg::WIN_PUSH) begin
         win_ff[fill_ff[mpmf_pkg::WinIdxW-1:0]] <= ctl.data;
      end
   end

   assign tail_pos    = fill_ff - 1'b1;
   assign status.head = win_ff[0];
   assign status.tail = win_ff[tail_pos[mpmf_pkg::WinIdxW-1:0]];
   assign status.fill = fill_ff;

endmodule

[hw/rtl/multi_pattern_mask_filter.sv]
// ----------------------------------------------------------------------------
// Multi-pattern mask filter
// Case-insensitive multi-pattern matcher that masks matched words in a byte
// stream, driven by a sequencer around one edge-table read port.
// ----------------------------------------------------------------------------
// A scan word holds req_stall until it is done: a full window first releases its
// oldest word (waiting on output stalls), the byte is pushed, its edge is looked
// up and fail links are walked, back to the root at the walk bound. A match then
// pops removed bytes one at a time and pushes the marker. Table writes are taken
// while idle. An end word flushes the window at one result word per cycle while
// rsp_stall is low. Reset: synchronous; the edge table is then swept clear under req_stall.
module multi_pattern_mask_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_state_index,
   input  logic [7:0]  req_edge_symbol,
   input  logic        req_edge_valid,
   input  logic [7:0]  req_edge_target,
   input  logic [7:0]  req_fail_target,
   input  logic [4:0]  req_match_len,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_string,
   output logic        rsp_any_replaced
);

   mpmf_pkg::seq_state_type         state_ff, state_in;
   logic [mpmf_pkg::StateW-1:0]     cur_ff, cur_in;
   logic [7:0]                      sym_ff, sym_in;
   logic [7:0]                      byte_ff, byte_in;
   logic [mpmf_pkg::StepW-1:0]      steps_ff, steps_in;
   logic [mpmf_pkg::LenW-1:0]       len_ff, len_in;
   logic [mpmf_pkg::LenW-1:0]       removed_ff, removed_in;
   logic                            replaced_ff, replaced_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   mpmf_pkg::kind_type              kind_ff, kind_in;
   logic [7:0]                      obyte_ff, obyte_in;
   logic                            last_ff, last_in;
   logic                            any_ff, any_in;

   logic                            accept;
   logic                            out_free;
   logic                            out_load;
   mpmf_pkg::action_type            act;
   logic [7:0]                      folded;

   logic                            edge_busy;
   logic [8:0]                      edge_q;
   logic                            edge_we;
   logic [8:0]                      edge_wdata;
   logic                            st_we;
   logic [mpmf_pkg::StateW-1:0]     st_fail;
   logic [mpmf_pkg::LenW-1:0]       st_len;

   mpmf_pkg::win_ctl_type           win_ctl;
   mpmf_pkg::win_status_type        win_st;

   // Handshake.
   assign act       = mpmf_pkg::action_type'(req_action);
   assign req_stall = (state_ff != mpmf_pkg::ST_IDLE) || edge_busy;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Case folding of the scanned byte.
   assign folded = ((req_data_byte >= mpmf_pkg::CharUpperA) &&
                    (req_data_byte <= mpmf_pkg::CharUpperZ)) ?
                   (req_data_byte - mpmf_pkg::CharUpperA + mpmf_pkg::CharLowerA) :
                   req_data_byte;

   // Table writes happen in the cycle the word is accepted.
   assign edge_we    = accept && (act == mpmf_pkg::ACT_EDGE_WR);
   assign edge_wdata = req_edge_valid ? {1'b1, req_edge_target} : 9'd0;
   assign st_we      = accept && (act == mpmf_pkg::ACT_STATE_WR);

   mpmf_edge_mem u_edge_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (edge_we),
      .wr_addr ({req_state_index, req_edge_symbol}),
      .wr_data (edge_wdata),
      .rd_addr ({cur_ff, sym_ff}),
      .rd_data (edge_q),
      .busy    (edge_busy)
   );

   mpmf_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (st_we),
      .wr_addr (req_state_index),
      .wr_fail (req_fail_target),
      .wr_len  (req_match_len),
      .rd_addr (cur_ff),
      .rd_fail (st_fail),
      .rd_len  (st_len)
   );

   mpmf_window u_window (
      .clock  (clock),
      .reset  (reset),
      .ctl    (win_ctl),
      .status (win_st)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpmf_pkg::ST_IDLE: begin
            if (accept && act == mpmf_pkg::ACT_SCAN) begin
               state_in = (win_st.fill == mpmf_pkg::FillW'(mpmf_pkg::MaxPattern)) ?
                          mpmf_pkg::ST_SCAN_SHIFT : mpmf_pkg::ST_SCAN_PUSH;
            end else if (accept && act == mpmf_pkg::ACT_END) begin
               state_in = mpmf_pkg::ST_FLUSH;
            end
         end
         mpmf_pkg::ST_SCAN_SHIFT: begin
            if (out_free) begin
               state_in = mpmf_pkg::ST_SCAN_PUSH;
            end
         end
         mpmf_pkg::ST_SCAN_PUSH: state_in = mpmf_pkg::ST_EDGE_RD;
         mpmf_pkg::ST_EDGE_RD:   state_in = mpmf_pkg::ST_EDGE_CHK;
         mpmf_pkg::ST_EDGE_CHK: begin
            if (edge_q[8] || cur_ff == '0) begin
               state_in = mpmf_pkg::ST_LEN_RD;
            end else if (steps_ff == mpmf_pkg::StepW'(mpmf_pkg::NumStates)) begin
               state_in = mpmf_pkg::ST_EDGE_RD;
            end else begin
               state_in = mpmf_pkg::ST_FAIL_RD;
            end
         end
         mpmf_pkg::ST_FAIL_RD:  state_in = mpmf_pkg::ST_FAIL_CHK;
         mpmf_pkg::ST_FAIL_CHK: state_in = mpmf_pkg::ST_EDGE_RD;
         mpmf_pkg::ST_LEN_RD:   state_in = mpmf_pkg::ST_LEN_CHK;
         mpmf_pkg::ST_LEN_CHK: begin
            state_in = (cur_ff != '0 && st_len != '0) ?
                       mpmf_pkg::ST_MASK : mpmf_pkg::ST_IDLE;
         end
         mpmf_pkg::ST_MASK: begin
            if (!(removed_ff < len_ff && win_st.fill != '0 && !win_st.tail[8])) begin
               state_in = mpmf_pkg::ST_IDLE;
            end
         end
         mpmf_pkg::ST_FLUSH: begin
            if (out_free && win_st.fill <= mpmf_pkg::FillW'(1)) begin
               state_in = mpmf_pkg::ST_IDLE;
            end
         end
         default: state_in = mpmf_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls and register updates.
   always_comb begin
      cur_in      = cur_ff;
      sym_in      = sym_ff;
      byte_in     = byte_ff;
      steps_in    = steps_ff;
      len_in      = len_ff;
      removed_in  = removed_ff;
      replaced_in = replaced_ff;
      win_ctl     = '{op: mpmf_pkg::WIN_NOP, data: '0};
      out_load    = 1'b0;
      kind_in     = kind_ff;
      obyte_in    = obyte_ff;
      last_in     = last_ff;
      any_in      = any_ff;

      case (state_ff)
         mpmf_pkg::ST_IDLE: begin
            if (accept && act == mpmf_pkg::ACT_SCAN) begin
               sym_in   = folded;
               byte_in  = req_data_byte;
               steps_in = '0;
            end
         end
         mpmf_pkg::ST_SCAN_SHIFT: begin
            // The oldest window word leaves to make room.
            if (out_free) begin
               out_load    = 1'b1;
               kind_in     = win_st.head[8] ? mpmf_pkg::KIND_MASK : mpmf_pkg::KIND_PLAIN;
               obyte_in    = win_st.head[8] ? 8'd0 : win_st.head[7:0];
               last_in     = 1'b0;
               any_in      = 1'b0;
               win_ctl.op  = mpmf_pkg::WIN_SHIFT;
            end
         end
         mpmf_pkg::ST_SCAN_PUSH: begin
            win_ctl.op   = mpmf_pkg::WIN_PUSH;
            win_ctl.data = {1'b0, byte_ff};
         end
         mpmf_pkg::ST_EDGE_CHK: begin
            if (edge_q[8]) begin
               cur_in = edge_q[mpmf_pkg::StateW-1:0];
            end else if (cur_ff != '0 &&
                         steps_ff == mpmf_pkg::StepW'(mpmf_pkg::NumStates)) begin
               // Walk bound reached: fall back to the root.
               cur_in = '0;
            end
         end
         mpmf_pkg::ST_FAIL_CHK: begin
            cur_in   = st_fail;
            steps_in = steps_ff + 1'b1;
         end
         mpmf_pkg::ST_LEN_CHK: begin
            len_in     = st_len;
            removed_in = '0;
         end
         mpmf_pkg::ST_MASK: begin
            // Drop trailing plain bytes one at a time, then place the marker.
            if (removed_ff < len_ff && win_st.fill != '0 && !win_st.tail[8]) begin
               win_ctl.op = mpmf_pkg::WIN_POP;
               removed_in = removed_ff + 1'b1;
            end else begin
               win_ctl.op   = mpmf_pkg::WIN_PUSH;
               win_ctl.data = 9'h100;
               cur_in       = '0;
               replaced_in  = 1'b1;
            end
         end
         mpmf_pkg::ST_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               if (win_st.fill == '0) begin
                  kind_in  = mpmf_pkg::KIND_NONE;
                  obyte_in = 8'd0;
                  last_in  = 1'b1;
                  any_in   = replaced_ff;
               end else begin
                  kind_in    = win_st.head[8] ? mpmf_pkg::KIND_MASK : mpmf_pkg::KIND_PLAIN;
                  obyte_in   = win_st.head[8] ? 8'd0 : win_st.head[7:0];
                  last_in    = (win_st.fill == mpmf_pkg::FillW'(1));
                  any_in     = (win_st.fill == mpmf_pkg::FillW'(1)) && replaced_ff;
                  win_ctl.op = mpmf_pkg::WIN_SHIFT;
               end
               if (win_st.fill <= mpmf_pkg::FillW'(1)) begin
                  cur_in      = '0;
                  replaced_in = 1'b0;
               end
            end
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   // Output register valid.
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpmf_pkg::ST_IDLE;
         cur_ff       <= '0;
         replaced_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         replaced_ff  <= replaced_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff     <= sym_in;
      byte_ff    <= byte_in;
      steps_ff   <= steps_in;
      len_ff     <= len_in;
      removed_ff <= removed_in;
      kind_ff    <= kind_in;
      obyte_ff   <= obyte_in;
      last_ff    <= last_in;
      any_ff     <= any_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_kind       = kind_ff;
   assign rsp_out_byte       = obyte_ff;
   assign rsp_last_of_string = last_ff;
   assign rsp_any_replaced   = any_ff;

endmodule
